@@ sv/rgb_hsv_pkg.sv @@
// Types, constants and the divider step shared by the RGB to HSV converter.
// Depends on nothing; imported by rgb_to_hsv_integer, hsv_result_checker and testbench.
`default_nettype none

package rgb_hsv_pkg;

  localparam int CH_W            = 8;
  localparam int NUM_DIV_STAGES  = 4;
  localparam int STEPS_PER_STAGE = CH_W / NUM_DIV_STAGES;
  // front stage, product stage, divider stages, output register
  localparam int LATENCY         = NUM_DIV_STAGES + 3;

  localparam logic [CH_W-1:0] SECTOR_RED   = 8'd0;
  localparam logic [CH_W-1:0] SECTOR_GREEN = 8'd85;
  localparam logic [CH_W-1:0] SECTOR_BLUE  = 8'd171;
  localparam logic [5:0]      HUE_SPAN     = 6'd43;

  // after the front stage: extremes, sector and the signed channel difference
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] span;
    logic [CH_W-1:0] offset;
    logic            neg;
    logic [CH_W-1:0] mag;
  } front_t;

  // one restoring division in flight: partial remainder, unused dividend bits, quotient
  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] low;
    logic [CH_W-1:0] quot;
  } div_t;

  typedef struct packed {
    logic            valid;
    logic            flat;
    logic            neg;
    logic [CH_W-1:0] offset;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] span;
    div_t            sdiv;
    div_t            hdiv;
  } pipe_t;

  // one quotient bit; rem < divisor holds on entry when the divisor is nonzero
  function automatic div_t div_step(input div_t d, input logic [CH_W-1:0] divisor);
    logic [CH_W:0] trial;
    div_t          r;
    trial  = {d.rem, d.low[CH_W-1]};
    r.low  = {d.low[CH_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      r.rem  = CH_W'(trial - {1'b0, divisor});
      r.quot = {d.quot[CH_W-2:0], 1'b1};
    end else begin
      r.rem  = trial[CH_W-1:0];
      r.quot = {d.quot[CH_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic pipe_t div_advance(input pipe_t p);
    pipe_t r;
    r = p;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      r.sdiv = div_step(r.sdiv, r.hi);
      r.hdiv = div_step(r.hdiv, r.span);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/rgb_to_hsv_integer.sv @@
// Pipelined 8-bit RGB to 8-bit HSV converter, top level.
// Depends on rgb_hsv_pkg for stage types, sector constants and the divider step.
//
//   channel   ports                           handshake
//   pixel in  red, green, blue                start, busy (busy is always low)
//   HSV out   hue, saturation, brightness     done, one-cycle strobe
//
// One pixel may enter every cycle; its result is registered stage by stage.
// Two restoring dividers (255*chroma/max and 43*diff/chroma) retire two quotient
// bits per stage over four stages; that divider chain sets the latency.
// Synchronous reset clears the stage registers and drops transactions in flight.
// The output side cannot stall, so nothing ever holds the pipe.
`default_nettype none

module rgb_to_hsv_integer
  import rgb_hsv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  output logic                 done,
  output logic [CH_W-1:0]      hue,
  output logic [CH_W-1:0]      saturation,
  output logic [CH_W-1:0]      brightness
);

  front_t          front;
  front_t          front_next;
  pipe_t           dpipe [NUM_DIV_STAGES+1];
  pipe_t           prod_next;
  logic [CH_W:0]   diff;
  logic [CH_W:0]   diff_abs;
  logic [CH_W-1:0] lo;
  logic [13:0]     hue_prod;
  logic [CH_W-1:0] hue_q;
  logic [CH_W-1:0] hue_next;

  assign busy = 1'b0;

  // front stage: max, min, sector and signed difference of the other two channels
  always_comb begin
    front_next.valid = start & ~busy;
    if (red >= green && red >= blue) begin
      front_next.hi     = red;
      front_next.offset = SECTOR_RED;
      diff              = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      front_next.hi     = green;
      front_next.offset = SECTOR_GREEN;
      diff              = {1'b0, blue} - {1'b0, red};
    end else begin
      front_next.hi     = blue;
      front_next.offset = SECTOR_BLUE;
      diff              = {1'b0, red} - {1'b0, green};
    end
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo)  lo = blue;
    front_next.span = front_next.hi - lo;
    front_next.neg  = diff[CH_W];
    diff_abs        = diff[CH_W] ? -diff : diff;
    front_next.mag  = diff_abs[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
    end else begin
      front <= front_next;
    end
  end

  // product stage: form both dividends and load the dividers
  always_comb begin
    logic [2*CH_W-1:0] sat_n;
    logic [2*CH_W-1:0] hue_n;
    hue_prod = 14'(front.mag) * 14'(HUE_SPAN);
    sat_n    = {front.span, 8'h00} - {8'h00, front.span};
    hue_n    = {2'b00, hue_prod};
    prod_next.valid     = front.valid;
    prod_next.flat      = (front.span == '0);
    prod_next.neg       = front.neg;
    prod_next.offset    = front.offset;
    prod_next.hi        = front.hi;
    prod_next.span      = front.span;
    prod_next.sdiv.rem  = sat_n[2*CH_W-1:CH_W];
    prod_next.sdiv.low  = sat_n[CH_W-1:0];
    prod_next.sdiv.quot = '0;
    prod_next.hdiv.rem  = hue_n[2*CH_W-1:CH_W];
    prod_next.hdiv.low  = hue_n[CH_W-1:0];
    prod_next.hdiv.quot = '0;
  end

  // divider stages: advance both divisions STEPS_PER_STAGE (two) quotient bits per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NUM_DIV_STAGES; k++) begin
        dpipe[k] <= '0;
      end
    end else begin
      dpipe[0] <= prod_next;
      for (int k = 1; k <= NUM_DIV_STAGES; k++) begin
        dpipe[k] <= div_advance(dpipe[k-1]);
      end
    end
  end

  // output stage: apply sign and sector; a grey or black pixel gets zero hue
  assign hue_q    = dpipe[NUM_DIV_STAGES].hdiv.quot;
  assign hue_next = dpipe[NUM_DIV_STAGES].offset
                  + (dpipe[NUM_DIV_STAGES].neg ? (~hue_q + 8'd1) : hue_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dpipe[NUM_DIV_STAGES].valid;
    end
    brightness <= dpipe[NUM_DIV_STAGES].hi;
    saturation <= dpipe[NUM_DIV_STAGES].flat ? '0 : dpipe[NUM_DIV_STAGES].sdiv.quot;
    hue        <= dpipe[NUM_DIV_STAGES].flat ? '0 : hue_next;
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted pixel did not produce a result on time");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching transaction");

  a_grey_zero_hue: assert property (@(posedge clk) disable iff (rst)
    (done && saturation == '0) |-> (hue == '0))
    else $error("zero saturation with nonzero hue");

  a_black_zero_sat: assert property (@(posedge clk) disable iff (rst)
    (done && brightness == '0) |-> (saturation == '0))
    else $error("black pixel with nonzero saturation");
`endif

endmodule

`default_nettype wire

@@ tb/hsv_result_checker.sv @@
// Result checker for the RGB to HSV converter: predicts each accepted pixel
// and compares the strobed HSV outputs in order. Depends on rgb_hsv_pkg for CH_W.
`timescale 1ns / 1ps

module hsv_result_checker
  import rgb_hsv_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  input  logic            done,
  input  logic [CH_W-1:0] hue,
  input  logic [CH_W-1:0] saturation,
  input  logic [CH_W-1:0] brightness,
  output int              mismatches,
  output int              outstanding
);

  localparam int OFS_RED    = 0;
  localparam int OFS_GREEN  = 85;
  localparam int OFS_BLUE   = 171;
  localparam int HUE_ARC    = 43;
  localparam int FULL_SCALE = 255;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] h;
    logic [CH_W-1:0] s;
    logic [CH_W-1:0] v;
  } hsv_expect_t;

  hsv_expect_t hsv_due[$];
  int          err_count = 0;

  function automatic hsv_expect_t convert_pixel(input logic [CH_W-1:0] r, g, b);
    int          ri, gi, bi, top, bottom, chroma, offset, diff, sat;
    hsv_expect_t res;
    ri = r;
    gi = g;
    bi = b;
    top = ri;
    if (gi > top) top = gi;
    if (bi > top) top = bi;
    bottom = ri;
    if (gi < bottom) bottom = gi;
    if (bi < bottom) bottom = bi;
    res.r = r;
    res.g = g;
    res.b = b;
    res.v = CH_W'(top);
    res.s = '0;
    res.h = '0;
    if (top != 0) begin
      chroma = top - bottom;
      sat    = (FULL_SCALE * chroma) / top;
      res.s  = CH_W'(sat);
      if (sat != 0) begin
        // red wins ties, then green
        if (top == ri) begin
          offset = OFS_RED;
          diff   = gi - bi;
        end else if (top == gi) begin
          offset = OFS_GREEN;
          diff   = bi - ri;
        end else begin
          offset = OFS_BLUE;
          diff   = ri - gi;
        end
        // signed int division truncates toward zero; the cast wraps modulo 256
        res.h = CH_W'(offset + (HUE_ARC * diff) / chroma);
      end
    end
    return res;
  endfunction

  task automatic check_field(input string field, input hsv_expect_t want,
                             input logic [CH_W-1:0] exp_val, got_val);
    if (got_val !== exp_val) begin
      err_count++;
      if (err_count <= REPORT_MAX)
        $display("%0t: %s mismatch for rgb (%0d,%0d,%0d): expected %0d, got %0d",
                 $realtime, field, want.r, want.g, want.b, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    hsv_expect_t head;
    if (!rst) begin
      // retire before accepting so a stray strobe cannot claim a fresh pixel
      if (done !== 1'b0) begin
        if (hsv_due.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: unexpected result h=%0d s=%0d v=%0d",
                     $realtime, hue, saturation, brightness);
        end else begin
          head = hsv_due.pop_front();
          check_field("hue", head, head.h, hue);
          check_field("saturation", head, head.s, saturation);
          check_field("brightness", head, head.v, brightness);
        end
      end
      if (start && busy !== 1'b1)
        hsv_due.push_back(convert_pixel(red, green, blue));
    end
    mismatches  <= err_count;
    outstanding <= hsv_due.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on rgb_hsv_pkg, rgb_to_hsv_integer and hsv_result_checker.
`timescale 1ns / 1ps

module testbench;
  import rgb_hsv_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PIXELS = 750;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            busy;
  logic            done;
  logic [CH_W-1:0] hue;
  logic [CH_W-1:0] saturation;
  logic [CH_W-1:0] brightness;
  int              mismatches;
  int              outstanding;
  int              cycles = 0;
  int              pixels_sent = 0;
  int              burst_left = 0;

  always #1 clk = ~clk;

  rgb_to_hsv_integer dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  hsv_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .done        (done),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // hold the pixel until the transaction is taken
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    red   <= r;
    green <= g;
    blue  <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy === 1'b1);
    pixels_sent++;
  endtask

  // mostly back to back, some short gaps, a few long ones, and bursts with none
  task automatic idle_gap();
    int pick, n;
    n = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      n = 0;
      else if (pick < 90) n = $urandom_range(1, 3);
      else if (pick < 97) n = $urandom_range(4, 9);
      else                n = $urandom_range(20, 60);
      if (pick == 0) burst_left = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [CH_W-1:0] clamp_channel(input int x);
    if (x < 0) return '0;
    if (x > 255) return 8'd255;
    return CH_W'(x);
  endfunction

  function automatic logic [3*CH_W-1:0] random_pixel();
    logic [31:0]     raw;
    logic [CH_W-1:0] a, c, r, g, b;
    int              k;
    raw = $urandom();
    r = raw[23:16];
    g = raw[15:8];
    b = raw[7:0];
    case ($urandom_range(0, 9))
      4: begin
        // near grey: tiny chroma stresses the hue division
        a = CH_W'($urandom_range(0, 255));
        r = clamp_channel(int'(a) + $urandom_range(0, 6) - 3);
        g = clamp_channel(int'(a) + $urandom_range(0, 6) - 3);
        b = clamp_channel(int'(a) + $urandom_range(0, 6) - 3);
      end
      5: begin
        // two channels tied at the maximum
        a = CH_W'($urandom_range(1, 255));
        c = CH_W'($urandom_range(0, a));
        k = $urandom_range(0, 2);
        r = (k == 2) ? c : a;
        g = (k == 1) ? c : a;
        b = (k == 0) ? c : a;
      end
      6: begin
        k = $urandom_range(0, 2);
        r = (k == 0) ? r : (raw[24] ? 8'd255 : 8'd0);
        g = (k == 1) ? g : (raw[25] ? 8'd255 : 8'd0);
        b = (k == 2) ? b : (raw[26] ? 8'd255 : 8'd0);
      end
      7: begin
        r = CH_W'($urandom_range(0, 7));
        g = CH_W'($urandom_range(0, 7));
        b = CH_W'($urandom_range(0, 7));
      end
      8: begin
        g = r;
        b = r;
      end
      9: begin
        k = $urandom_range(0, 2);
        if (k == 0) r = 8'd255;
        else if (k == 1) g = 8'd255;
        else b = 8'd255;
      end
      default: ;
    endcase
    return {r, g, b};
  endfunction

  initial begin
    logic [3*CH_W-1:0] px;
    int                corner_count;
    rst   = 1'b1;
    start = 1'b0;
    red   = '0;
    green = '0;
    blue  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // black, greys, primaries, tied maxima, negative hue offset in every sector (wrapping in red)
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    idle_gap();
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    idle_gap();
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd200);
    send_pixel(8'd0,   8'd200, 8'd255);
    idle_gap();
    send_pixel(8'd200, 8'd255, 8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd1,   8'd0);
    idle_gap();
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd10,  8'd20,  8'd30);
    send_pixel(8'd85,  8'd170, 8'd85);
    corner_count = pixels_sent;

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS / 2) begin
        // drain the pipe completely once mid-run
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end else begin
        idle_gap();
      end
      px = random_pixel();
      send_pixel(px[23:16], px[15:8], px[7:0]);
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Converted %0d pixels: %0d directed (black, grey, primaries, tied maxima,",
             pixels_sent, corner_count);
    $display("wrapped hue) and %0d random, with idle gaps, bursts and a mid-run drain",
             pixels_sent - corner_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rgb_hsv_pkg.sv
sv/rgb_to_hsv_integer.sv
tb/hsv_result_checker.sv
tb/testbench.sv
